### hdl/csl_pkg.sv
// Package for the C-subset lexer: record, kind and mode codes and the byte classifiers.
// Used by csl_step and c_subset_lexer; it has no dependencies of its own.
package csl_pkg;

   localparam int unsigned ID_CHARS   = 32;
   localparam int unsigned TEXT_CHARS = 256;
   localparam int unsigned LEN_W      = 9;

   localparam logic [1:0] REC_TEXT  = 2'd0;
   localparam logic [1:0] REC_TOKEN = 2'd1;
   localparam logic [1:0] REC_ERROR = 2'd2;

   localparam logic [4:0] K_EOF    = 5'd0;
   localparam logic [4:0] K_IDENT  = 5'd1;
   localparam logic [4:0] K_INT    = 5'd2;
   localparam logic [4:0] K_STRING = 5'd3;
   localparam logic [4:0] K_IF     = 5'd4;
   localparam logic [4:0] K_ELSE   = 5'd5;
   localparam logic [4:0] K_INTKW  = 5'd6;
   localparam logic [4:0] K_VOID   = 5'd7;
   localparam logic [4:0] K_EQ     = 5'd14;
   localparam logic [4:0] K_NE     = 5'd15;
   localparam logic [4:0] K_LE     = 5'd17;
   localparam logic [4:0] K_GE     = 5'd19;
   localparam logic [4:0] K_OTHER  = 5'd24;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_CHAR_LONG = 3'd1;
   localparam logic [2:0] ERR_NO_QUOTE  = 3'd2;
   localparam logic [2:0] ERR_NO_DQUOTE = 3'd3;
   localparam logic [2:0] ERR_STR_LONG  = 3'd4;

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_IDENT = 3'd1;
   localparam logic [2:0] M_NUM   = 3'd2;
   localparam logic [2:0] M_CHAR  = 3'd3;
   localparam logic [2:0] M_STR   = 3'd4;
   localparam logic [2:0] M_OP    = 3'd5;

   typedef struct packed {
      logic [1:0]  rec_type;
      logic [4:0]  tok_kind;
      logic [31:0] tok_value;
      logic [7:0]  text_char;
      logic [8:0]  text_len;
      logic [2:0]  err_code;
   } rec_type_type;

   // Lexer state carried from one byte to the next (counters kept apart).
   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  pending_op;
      logic [31:0] kw_buffer;
      logic [8:0]  text_count;
      logic [31:0] num_accum;
      logic [1:0]  literal_count;
   } lex_state_type;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] b);
      logic [4:0] k;
      case (b)
         8'h28:   k = 5'd8;
         8'h29:   k = 5'd9;
         8'h2B:   k = 5'd10;
         8'h2D:   k = 5'd11;
         8'h2A:   k = 5'd12;
         8'h2F:   k = 5'd13;
         8'h3C:   k = 5'd16;
         8'h3E:   k = 5'd18;
         8'h3D:   k = 5'd20;
         8'h3B:   k = 5'd21;
         8'h3A:   k = 5'd22;
         8'h2C:   k = 5'd23;
         default: k = K_OTHER;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] pair_kind(input logic [7:0] first);
      logic [4:0] k;
      case (first)
         8'h3D:   k = K_EQ;
         8'h21:   k = K_NE;
         8'h3C:   k = K_LE;
         default: k = K_GE;
      endcase
      return k;
   endfunction

   function automatic rec_type_type text_rec(input logic [7:0] b);
      rec_type_type r;
      r = '0;
      r.rec_type  = REC_TEXT;
      r.text_char = b;
      return r;
   endfunction

   function automatic rec_type_type tok_rec(input logic [4:0] k, input logic [31:0] v,
                                            input logic [8:0] len);
      rec_type_type r;
      r = '0;
      r.rec_type  = REC_TOKEN;
      r.tok_kind  = k;
      r.tok_value = v;
      r.text_len  = len;
      return r;
   endfunction

   function automatic rec_type_type err_rec(input logic [2:0] e);
      rec_type_type r;
      r = '0;
      r.rec_type = REC_ERROR;
      r.err_code = e;
      return r;
   endfunction

endpackage

### hdl/c_subset_lexer.sv
// Top level of the C-subset lexer: one-pass step logic and a result queue.
// Depends on csl_pkg and csl_step.
//
// Usage: the req_ channel carries one source byte (req_src_byte) or an end-of-text
// mark (req_end_mark) per transfer. The rsp_ channel delivers records one per
// transfer: text bytes, completed tokens and errors, each stamped with the line and
// column after the byte that caused it; rsp_last_of_run marks the final record of
// one input transfer. A byte may cause no record at all.
// Each accepted byte is processed in the cycle it is accepted and its zero to three
// records are registered into a small result queue and offered from its head. A new
// byte is taken every cycle as long as the queue has room for three more records;
// the sustained rate is one byte per cycle when the receiver takes records as fast
// as they appear, and is set by the one-record-per-cycle output port when bytes
// produce several records each.
// Reset (synchronous, active high) returns the lexer to idle between tokens with
// line and column zero and empties the queue. When the receiver stalls, the head
// record is held stable and req_stall rises once the queue cannot take a worst-case
// byte. An end mark flushes a pending token or literal error, emits eof, restarts.
module c_subset_lexer
   import csl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_src_byte,
   input  logic         req_end_mark,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [1:0]   rsp_rec_type,
   output logic [4:0]   rsp_tok_kind,
   output logic signed [31:0] rsp_tok_value,
   output logic [7:0]   rsp_text_char,
   output logic [8:0]   rsp_text_len,
   output logic [31:0]  rsp_line_no,
   output logic [31:0]  rsp_col_no,
   output logic [2:0]   rsp_err_code,
   output logic         rsp_last_of_run
);

   // Queue entry: the record plus its position stamp and last flag.
   typedef struct packed {
      rec_type_type rec;
      logic [31:0]  line_no;
      logic [31:0]  col_no;
      logic         last;
   } q_entry_type;

   localparam int unsigned QD = 8;

   lex_state_type state_ff, state_in;
   logic [31:0]   line_ff, line_in, col_ff, col_in;
   q_entry_type   q_ff [QD];
   logic [2:0]    rd_ff, wr_ff;
   logic [3:0]    cnt_ff;
   rec_type_type  recs [3];
   logic [1:0]    rec_count;
   logic          take, give;

   assign req_stall = cnt_ff > 4'(QD - 3);
   assign take = req_valid && !req_stall;
   assign rsp_valid = cnt_ff != 4'd0;
   assign give = rsp_valid && !rsp_stall;

   csl_step u_step (
      .cur       (state_ff),
      .src_byte  (req_src_byte),
      .end_mark  (req_end_mark),
      .nxt       (state_in),
      .recs      (recs),
      .rec_count (rec_count)
   );

   // Line and column count the consumed byte; an end mark restarts them.
   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (req_end_mark) begin
         line_in = 32'd0;
         col_in  = 32'd0;
      end else if (req_src_byte == 8'h0A) begin
         if (line_ff != 32'hFFFF_FFFF) line_in = line_ff + 32'd1;
         col_in = 32'd0;
      end else if (col_ff != 32'hFFFF_FFFF) begin
         col_in = col_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         line_ff  <= 32'd0;
         col_ff   <= 32'd0;
         rd_ff    <= 3'd0;
         wr_ff    <= 3'd0;
         cnt_ff   <= 4'd0;
      end else begin
         if (take) begin
            state_ff <= state_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            wr_ff    <= wr_ff + 3'(rec_count);
         end
         if (give) rd_ff <= rd_ff + 3'd1;
         cnt_ff <= cnt_ff + (take ? 4'(rec_count) : 4'd0) - (give ? 4'd1 : 4'd0);
      end
   end

   // Records are stamped with the counters as they stand after this byte; an end
   // mark's records carry the counters before they restart.
   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < rec_count) begin
               q_ff[wr_ff + 3'(i)].rec     <= recs[i];
               q_ff[wr_ff + 3'(i)].line_no <= req_end_mark ? line_ff : line_in;
               q_ff[wr_ff + 3'(i)].col_no  <= req_end_mark ? col_ff : col_in;
               q_ff[wr_ff + 3'(i)].last    <= 2'(i) == rec_count - 2'd1;
            end
         end
      end
   end

   assign rsp_rec_type    = q_ff[rd_ff].rec.rec_type;
   assign rsp_tok_kind    = q_ff[rd_ff].rec.tok_kind;
   assign rsp_tok_value   = q_ff[rd_ff].rec.tok_value;
   assign rsp_text_char   = q_ff[rd_ff].rec.text_char;
   assign rsp_text_len    = q_ff[rd_ff].rec.text_len;
   assign rsp_line_no     = q_ff[rd_ff].line_no;
   assign rsp_col_no      = q_ff[rd_ff].col_no;
   assign rsp_err_code    = q_ff[rd_ff].rec.err_code;
   assign rsp_last_of_run = q_ff[rd_ff].last;

endmodule

### hdl/csl_step.sv
// Next-state and record logic of the C-subset lexer for one accepted byte or end mark.
// Depends on csl_pkg; purely combinational, used by c_subset_lexer.
module csl_step
   import csl_pkg::*;
(
   input  lex_state_type    cur,
   input  logic [7:0]       src_byte,
   input  logic             end_mark,
   output lex_state_type    nxt,
   output rec_type_type     recs [3],
   output logic [1:0]       rec_count
);

   logic [4:0]    id_kind;
   logic          id_cont;
   logic          reproc;
   logic [7:0]    b;
   logic [31:0]   num_x10;

   assign b = src_byte;
   assign num_x10 = (cur.num_accum << 3) + (cur.num_accum << 1);

   always_comb begin
      id_kind = K_IDENT;
      if (cur.text_count == 9'd2 && cur.kw_buffer == 32'h0000_6669) id_kind = K_IF;
      else if (cur.text_count == 9'd4 && cur.kw_buffer == 32'h6573_6C65) id_kind = K_ELSE;
      else if (cur.text_count == 9'd3 && cur.kw_buffer == 32'h0074_6E69) id_kind = K_INTKW;
      else if (cur.text_count == 9'd4 && cur.kw_buffer == 32'h6469_6F76) id_kind = K_VOID;
   end

   always_comb begin
      nxt       = cur;
      recs[0]   = '0;
      recs[1]   = '0;
      recs[2]   = '0;
      rec_count = 2'd0;
      reproc    = 1'b0;
      id_cont   = 1'b0;

      if (end_mark) begin
         case (cur.mode)
            M_IDENT: begin
               recs[0] = tok_rec(id_kind, 32'd0, cur.text_count);
               rec_count = 2'd1;
            end
            M_NUM: begin
               recs[0] = tok_rec(K_INT, cur.num_accum, 9'd0);
               rec_count = 2'd1;
            end
            M_CHAR: begin
               recs[0] = err_rec(cur.literal_count == 2'd2 ? ERR_CHAR_LONG : ERR_NO_QUOTE);
               rec_count = 2'd1;
            end
            M_STR: begin
               recs[0] = err_rec(ERR_NO_DQUOTE);
               rec_count = 2'd1;
            end
            M_OP: begin
               recs[0] = tok_rec(single_kind(cur.pending_op), 32'd0, 9'd1);
               rec_count = 2'd1;
            end
            default: ;
         endcase
         recs[rec_count] = tok_rec(K_EOF, 32'd0, 9'd0);
         rec_count = rec_count + 2'd1;
         nxt = '0;
      end else begin
         case (cur.mode)
            M_IDENT: begin
               if (is_letter(b) || is_digit(b)) begin
                  id_cont = 1'b1;
               end else begin
                  recs[0] = tok_rec(id_kind, 32'd0, cur.text_count);
                  rec_count = 2'd1;
                  reproc = 1'b1;
               end
            end
            M_NUM: begin
               if (is_digit(b)) begin
                  nxt.num_accum = num_x10 + {24'd0, b - 8'h30};
               end else begin
                  recs[0] = tok_rec(K_INT, cur.num_accum, 9'd0);
                  rec_count = 2'd1;
                  reproc = 1'b1;
               end
            end
            M_CHAR: begin
               if (b == 8'h27 || b == 8'h0A) begin
                  if (cur.literal_count == 2'd2) recs[0] = err_rec(ERR_CHAR_LONG);
                  else if (b == 8'h0A) recs[0] = err_rec(ERR_NO_QUOTE);
                  else recs[0] = tok_rec(K_INT, cur.num_accum, cur.text_count);
                  rec_count = 2'd1;
                  nxt.mode = M_IDLE;
               end else if (cur.literal_count == 2'd0) begin
                  nxt.num_accum = {24'd0, b};
                  nxt.text_count = 9'd1;
                  nxt.literal_count = 2'd1;
                  recs[0] = text_rec(b);
                  rec_count = 2'd1;
               end else begin
                  nxt.literal_count = 2'd2;
               end
            end
            M_STR: begin
               if (b == 8'h22) begin
                  recs[0] = tok_rec(K_STRING, 32'd0, cur.text_count);
                  rec_count = 2'd1;
                  nxt.mode = M_IDLE;
               end else if (b == 8'h0A) begin
                  recs[0] = err_rec(ERR_NO_DQUOTE);
                  rec_count = 2'd1;
                  nxt.mode = M_IDLE;
               end else if ({1'b0, cur.text_count} < LEN_W'(TEXT_CHARS) + 10'd0) begin
                  nxt.text_count = cur.text_count + 9'd1;
                  recs[0] = text_rec(b);
                  rec_count = 2'd1;
               end else begin
                  recs[0] = err_rec(ERR_STR_LONG);
                  rec_count = 2'd1;
                  nxt.mode = M_IDLE;
               end
            end
            M_OP: begin
               nxt.mode = M_IDLE;
               nxt.pending_op = 8'd0;
               if (b == 8'h3D) begin
                  recs[0] = text_rec(b);
                  recs[1] = tok_rec(pair_kind(cur.pending_op), 32'd0, 9'd2);
                  rec_count = 2'd2;
               end else begin
                  recs[0] = tok_rec(single_kind(cur.pending_op), 32'd0, 9'd1);
                  rec_count = 2'd1;
                  reproc = 1'b1;
               end
            end
            default: reproc = 1'b1;
         endcase

         if (reproc) begin
            nxt.mode = M_IDLE;
            if (is_space(b)) begin
               nxt.mode = M_IDLE;
            end else if (is_letter(b)) begin
               nxt.mode = M_IDENT;
               nxt.text_count = 9'd0;
               nxt.kw_buffer = 32'd0;
               id_cont = 1'b1;
            end else if (is_digit(b)) begin
               nxt.mode = M_NUM;
               nxt.num_accum = {24'd0, b - 8'h30};
            end else if (b == 8'h27) begin
               nxt.mode = M_CHAR;
               nxt.literal_count = 2'd0;
               nxt.num_accum = 32'd0;
               nxt.text_count = 9'd0;
            end else if (b == 8'h22) begin
               nxt.mode = M_STR;
               nxt.text_count = 9'd0;
            end else if (b == 8'h3C || b == 8'h3E || b == 8'h3D || b == 8'h21) begin
               recs[rec_count] = text_rec(b);
               rec_count = rec_count + 2'd1;
               nxt.pending_op = b;
               nxt.mode = M_OP;
            end else begin
               recs[rec_count] = text_rec(b);
               recs[rec_count + 2'd1] = tok_rec(single_kind(b), 32'd0, 9'd1);
               rec_count = rec_count + 2'd2;
            end
         end

         // Below the limit an identifier byte is echoed; bytes 0-3 fill kw_buffer.
         if (id_cont && nxt.text_count < 9'(ID_CHARS)) begin
            case (nxt.text_count[1:0])
               2'd0: if (nxt.text_count < 9'd4) nxt.kw_buffer[7:0]   = b;
               2'd1: if (nxt.text_count < 9'd4) nxt.kw_buffer[15:8]  = b;
               2'd2: if (nxt.text_count < 9'd4) nxt.kw_buffer[23:16] = b;
               default: if (nxt.text_count < 9'd4) nxt.kw_buffer[31:24] = b;
            endcase
            recs[rec_count] = text_rec(b);
            rec_count = rec_count + 2'd1;
            nxt.text_count = nxt.text_count + 9'd1;
         end
      end
   end

endmodule
